FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, quiet while reset is asserted.
`define SMEU_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Hold check: a signal keeps its value in the cycle after the condition.
`define SMEU_ASSERT_HOLD(label, cond, sig, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		cond |=> $stable(sig)) else $error(msg);

`endif

FILE: rtl/smeu_pkg.sv
package smeu_pkg;

	localparam int STACK_DEPTH = 256;
	localparam int VAR_COUNT   = 256;
	localparam int PC_BITS     = 16;
	localparam int WORD_W      = 32;
	localparam int NPC_W       = 16;
	localparam int SP_W        = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int VIDX_W      = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;

	// Opcodes
	localparam logic [7:0] OP_NOP    = 8'd0;
	localparam logic [7:0] OP_PUSH   = 8'd1;
	localparam logic [7:0] OP_POP    = 8'd2;
	localparam logic [7:0] OP_IADD   = 8'd3;
	localparam logic [7:0] OP_ISUB   = 8'd4;
	localparam logic [7:0] OP_IMUL   = 8'd5;
	localparam logic [7:0] OP_IDIV   = 8'd6;
	localparam logic [7:0] OP_IMOD   = 8'd7;
	localparam logic [7:0] OP_INC    = 8'd8;
	localparam logic [7:0] OP_DEC    = 8'd9;
	localparam logic [7:0] OP_AND    = 8'd10;
	localparam logic [7:0] OP_OR     = 8'd11;
	localparam logic [7:0] OP_NOT    = 8'd12;
	localparam logic [7:0] OP_XOR    = 8'd13;
	localparam logic [7:0] OP_SHL    = 8'd14;
	localparam logic [7:0] OP_SHR    = 8'd15;
	localparam logic [7:0] OP_LDVAR  = 8'd16;
	localparam logic [7:0] OP_STVAR  = 8'd17;
	localparam logic [7:0] OP_DUP    = 8'd18;
	localparam logic [7:0] OP_SWAP   = 8'd19;
	localparam logic [7:0] OP_ROT    = 8'd20;
	localparam logic [7:0] OP_IFEQ   = 8'd21;
	localparam logic [7:0] OP_IFNE   = 8'd22;
	localparam logic [7:0] OP_IFGT   = 8'd23;
	localparam logic [7:0] OP_IFLT   = 8'd24;
	localparam logic [7:0] OP_GOTO   = 8'd25;
	localparam logic [7:0] OP_EMIT   = 8'd26;
	localparam logic [7:0] OP_HALT   = 8'd27;

	// Run status codes
	localparam logic [2:0] ST_RUN    = 3'd0;
	localparam logic [2:0] ST_HALT   = 3'd1;
	localparam logic [2:0] ST_OVF    = 3'd2;
	localparam logic [2:0] ST_UNF    = 3'd3;
	localparam logic [2:0] ST_DIV0   = 3'd4;
	localparam logic [2:0] ST_UNK    = 3'd5;
	localparam logic [2:0] ST_BADIDX = 3'd6;

	typedef struct packed {
		logic       accept;
		logic       rd_first;
		logic       rd_second;
		logic       rd_third;
		logic       exec;
		logic       div_start;
		logic       div_capture;
		logic       wr_en;
		logic [1:0] wr_idx;
		logic       commit;
	} smeu_cmd_t;

	typedef struct packed {
		logic       dec_div;
		logic       div_done;
		logic [1:0] wr_count;
		logic       out_free;
	} smeu_sts_t;

endpackage

FILE: rtl/smeu_div.sv
module smeu_div import smeu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              is_mod,
	input  logic [WORD_W-1:0] dividend,
	input  logic [WORD_W-1:0] divisor,
	output logic              done,
	output logic [WORD_W-1:0] result
);

	localparam int STEP_W = $clog2(WORD_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] quo_q;
	logic [WORD_W-1:0] dvs_q;
	logic              negq_q;
	logic              negr_q;
	logic              mod_q;
	logic [WORD_W:0]   rem_sh;
	logic [WORD_W:0]   diff;
	logic [WORD_W-1:0] rem_nx;
	logic              bit_nx;

	// One restoring step on magnitudes
	always_comb begin
		rem_sh = {rem_q, quo_q[WORD_W-1]};
		diff   = rem_sh - {1'b0, dvs_q};
		if (!diff[WORD_W]) begin
			rem_nx = diff[WORD_W-1:0];
			bit_nx = 1'b1;
		end else begin
			rem_nx = rem_sh[WORD_W-1:0];
			bit_nx = 1'b0;
		end
	end

	// Sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(WORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Hold operands and partial results
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q  <= dividend[WORD_W-1] ? (~dividend + 1'b1) : dividend;
			dvs_q  <= divisor[WORD_W-1] ? (~divisor + 1'b1) : divisor;
			rem_q  <= '0;
			negq_q <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
			negr_q <= dividend[WORD_W-1];
			mod_q  <= is_mod;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[WORD_W-2:0], bit_nx};
		end
	end

	// Apply signs: truncating quotient, remainder takes the dividend sign
	always_comb begin
		if (mod_q)
			result = negr_q ? (~rem_q + 1'b1) : rem_q;
		else
			result = negq_q ? (~quo_q + 1'b1) : quo_q;
	end

	assign done = done_q;

endmodule

FILE: rtl/smeu_ctrl.sv
module smeu_ctrl import smeu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  smeu_sts_t sts,
	output smeu_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD1,
		S_RD2,
		S_RD3,
		S_EXEC,
		S_DIV,
		S_WR,
		S_COMMIT
	} state_t;

	state_t     state_q;
	logic [1:0] wr_idx_q;

	// Decode commands from state
	always_comb begin
		cmd        = '0;
		cmd.wr_idx = wr_idx_q;
		unique case (state_q)
			S_IDLE:   cmd.accept      = in_valid;
			S_RD1:    cmd.rd_first    = 1'b1;
			S_RD2:    cmd.rd_second   = 1'b1;
			S_RD3:    cmd.rd_third    = 1'b1;
			S_EXEC: begin
				cmd.exec      = 1'b1;
				cmd.div_start = sts.dec_div;
			end
			S_DIV:    cmd.div_capture = sts.div_done;
			S_WR:     cmd.wr_en       = (wr_idx_q != sts.wr_count);
			S_COMMIT: cmd.commit      = sts.out_free;
			default:  cmd             = '0;
		endcase
	end

	assign in_stall = (state_q != S_IDLE);

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			wr_idx_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_RD1;
				end
				S_RD1: state_q <= S_RD2;
				S_RD2: state_q <= S_RD3;
				S_RD3: state_q <= S_EXEC;
				S_EXEC: begin
					wr_idx_q <= '0;
					state_q  <= sts.dec_div ? S_DIV : S_WR;
				end
				S_DIV: begin
					if (sts.div_done)
						state_q <= S_WR;
				end
				S_WR: begin
					if (wr_idx_q == sts.wr_count)
						state_q <= S_COMMIT;
					else
						wr_idx_q <= wr_idx_q + 1'b1;
				end
				S_COMMIT: begin
					if (sts.out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/smeu_dp.sv
module smeu_dp import smeu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  smeu_cmd_t          cmd,
	output smeu_sts_t          sts,
	input  logic [7:0]         action,
	input  logic signed [31:0] operand,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        next_pc,
	output logic               print_valid,
	output logic signed [31:0] print_value,
	output logic signed [31:0] top_value,
	output logic [8:0]         depth,
	output logic [2:0]         status
);

	// Architectural state
	logic [CNT_W-1:0]   cnt_q;
	logic [PC_BITS-1:0] pc_q;
	logic [2:0]         stat_q;
	logic [WORD_W-1:0]  top_q;

	// Instruction and operands
	logic [7:0]        op_q;
	logic [WORD_W-1:0] w_q;
	logic [WORD_W-1:0] stk_rd_q;
	logic [WORD_W-1:0] t1_q;
	logic [WORD_W-1:0] t2_q;
	logic [WORD_W-1:0] var_rd_q;
	logic              var_rdv_q;

	// Stores
	logic [WORD_W-1:0]    stk_mem [STACK_DEPTH];
	logic [WORD_W-1:0]    var_mem [VAR_COUNT];
	logic [VAR_COUNT-1:0] var_vld_q;

	// Registered plan
	logic [2:0]               st_q;
	logic [CNT_W-1:0]         nn_q;
	logic [PC_BITS-1:0]       nxt_q;
	logic [WORD_W-1:0]        ntop_q;
	logic                     pv_q;
	logic [WORD_W-1:0]        pval_q;
	logic                     vwr_q;
	logic [1:0]               wcnt_q;
	logic [3:0][SP_W-1:0]     wa_q;
	logic [3:0][WORD_W-1:0]   wd_q;

	// Output register
	logic               ov_q;
	logic [NPC_W-1:0]   o_pc_q;
	logic               o_pv_q;
	logic [WORD_W-1:0]  o_pval_q;
	logic [WORD_W-1:0]  o_top_q;
	logic [CNT_W-1:0]   o_depth_q;
	logic [2:0]         o_st_q;

	// Decode results
	logic [2:0]             d_st;
	logic [CNT_W-1:0]       d_nn;
	logic [PC_BITS-1:0]     d_nxt;
	logic [WORD_W-1:0]      d_top;
	logic                   d_pv;
	logic [WORD_W-1:0]      d_pval;
	logic                   d_vwr;
	logic [1:0]             d_wcnt;
	logic [3:0][SP_W-1:0]   d_wa;
	logic [3:0][WORD_W-1:0] d_wd;
	logic                   d_div;

	logic [CNT_W-1:0]   cnt_m1;
	logic [CNT_W-1:0]   cnt_m2;
	logic [CNT_W-1:0]   cnt_m3;
	logic [SP_W-1:0]    rd_addr;
	logic               has1;
	logic               has2;
	logic               has3;
	logic               room;
	logic               idx_ok;
	logic [PC_BITS-1:0] pc1;
	logic [PC_BITS-1:0] pc2;
	logic [WORD_W-1:0]  t0;
	logic [WORD_W-1:0]  vval;
	logic [WORD_W-1:0]  alu_r;
	logic [WORD_W-1:0]  pop_top;
	logic               take;
	logic               div_done;
	logic [WORD_W-1:0]  div_res;
	logic [WORD_W-1:0]  pc_ext;

	assign cnt_m1  = cnt_q - 1'b1;
	assign cnt_m2  = cnt_q - CNT_W'(2);
	assign cnt_m3  = cnt_q - CNT_W'(3);
	assign rd_addr = cmd.rd_first ? cnt_m2[SP_W-1:0] : cnt_m3[SP_W-1:0];
	assign has1    = (cnt_q != '0);
	assign has2    = (cnt_q >= CNT_W'(2));
	assign has3    = (cnt_q >= CNT_W'(3));
	assign room    = (cnt_q < CNT_W'(STACK_DEPTH));
	assign idx_ok  = !w_q[WORD_W-1] && (w_q < WORD_W'(VAR_COUNT));
	assign pc1     = pc_q + 1'b1;
	assign pc2     = pc_q + PC_BITS'(2);
	assign t0      = top_q;
	assign vval    = var_rdv_q ? var_rd_q : '0;
	assign pop_top = has2 ? t1_q : '0;

	// Capture the instruction on input transfer
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q <= action;
			w_q  <= operand;
		end
	end

	// Stack memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.wr_en)
			stk_mem[wa_q[cmd.wr_idx]] <= wd_q[cmd.wr_idx];
		stk_rd_q <= stk_mem[rd_addr];
	end

	// Latch second and third entries as reads return
	always_ff @(posedge clk) begin
		if (cmd.rd_second)
			t1_q <= stk_rd_q;
		if (cmd.rd_third)
			t2_q <= stk_rd_q;
	end

	// Local variable memory with per-entry written flags
	always_ff @(posedge clk) begin
		if (cmd.commit && vwr_q)
			var_mem[w_q[VIDX_W-1:0]] <= t0;
		var_rd_q <= var_mem[w_q[VIDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			var_vld_q <= '0;
			var_rdv_q <= 1'b0;
		end else begin
			if (cmd.commit && vwr_q)
				var_vld_q[w_q[VIDX_W-1:0]] <= 1'b1;
			var_rdv_q <= var_vld_q[w_q[VIDX_W-1:0]];
		end
	end

	// ALU: t1 is the left operand, t0 the right; inc, dec and not use t0 alone
	always_comb begin
		unique case (op_q)
			OP_IADD: alu_r = t1_q + t0;
			OP_ISUB: alu_r = t1_q - t0;
			OP_IMUL: alu_r = t1_q * t0;
			OP_AND:  alu_r = t1_q & t0;
			OP_OR:   alu_r = t1_q | t0;
			OP_XOR:  alu_r = t1_q ^ t0;
			OP_SHL:  alu_r = t1_q << t0[4:0];
			OP_SHR:  alu_r = WORD_W'($signed(t1_q) >>> t0[4:0]);
			OP_INC:  alu_r = t0 + 1'b1;
			OP_DEC:  alu_r = t0 - 1'b1;
			OP_NOT:  alu_r = ~t0;
			default: alu_r = '0;
		endcase
	end

	// Branch condition on popped top
	always_comb begin
		unique case (op_q)
			OP_IFEQ: take = (t0 == '0);
			OP_IFNE: take = (t0 != '0);
			OP_IFGT: take = (t0 != '0) && !t0[WORD_W-1];
			OP_IFLT: take = t0[WORD_W-1];
			default: take = 1'b0;
		endcase
	end

	// Decode the instruction into a plan of writes and new state
	always_comb begin
		d_st   = ST_RUN;
		d_nn   = cnt_q;
		d_nxt  = pc1;
		d_top  = top_q;
		d_pv   = 1'b0;
		d_pval = '0;
		d_vwr  = 1'b0;
		d_wcnt = 2'd0;
		d_wa   = '0;
		d_wd   = '0;
		d_div  = 1'b0;
		unique case (op_q)
			OP_NOP: d_st = ST_RUN;
			OP_PUSH: begin
				d_nxt = pc2;
				if (!room) begin
					d_st = ST_OVF;
				end else begin
					d_wa[0] = cnt_q[SP_W-1:0];
					d_wd[0] = w_q;
					d_wcnt  = 2'd1;
					d_nn    = cnt_q + 1'b1;
					d_top   = w_q;
				end
			end
			OP_POP: begin
				if (!has1) begin
					d_st = ST_UNF;
				end else begin
					d_nn  = cnt_m1;
					d_top = pop_top;
				end
			end
			OP_IADD, OP_ISUB, OP_IMUL, OP_IDIV, OP_IMOD,
			OP_AND, OP_OR, OP_XOR, OP_SHL, OP_SHR: begin
				if (!has2) begin
					d_st = ST_UNF;
				end else if ((op_q == OP_IDIV || op_q == OP_IMOD) && t0 == '0) begin
					d_st = ST_DIV0;
				end else begin
					d_div   = (op_q == OP_IDIV || op_q == OP_IMOD);
					d_wa[0] = cnt_m2[SP_W-1:0];
					d_wd[0] = alu_r;
					d_wcnt  = 2'd1;
					d_nn    = cnt_m1;
					d_top   = alu_r;
				end
			end
			OP_INC, OP_DEC, OP_NOT: begin
				if (!has1) begin
					d_st = ST_UNF;
				end else begin
					d_wa[0] = cnt_m1[SP_W-1:0];
					d_wd[0] = alu_r;
					d_wcnt  = 2'd1;
					d_top   = alu_r;
				end
			end
			OP_LDVAR: begin
				d_nxt = pc2;
				if (!idx_ok) begin
					d_st = ST_BADIDX;
				end else if (!room) begin
					d_st = ST_OVF;
				end else begin
					d_wa[0] = cnt_q[SP_W-1:0];
					d_wd[0] = vval;
					d_wcnt  = 2'd1;
					d_nn    = cnt_q + 1'b1;
					d_top   = vval;
				end
			end
			OP_STVAR: begin
				d_nxt = pc2;
				if (!has1) begin
					d_st = ST_UNF;
				end else if (!idx_ok) begin
					d_st = ST_BADIDX;
				end else begin
					d_vwr = 1'b1;
					d_nn  = cnt_m1;
					d_top = pop_top;
				end
			end
			OP_DUP: begin
				if (!has1) begin
					d_st = ST_UNF;
				end else if (!room) begin
					d_st = ST_OVF;
				end else begin
					d_wa[0] = cnt_q[SP_W-1:0];
					d_wd[0] = t0;
					d_wcnt  = 2'd1;
					d_nn    = cnt_q + 1'b1;
				end
			end
			OP_SWAP: begin
				if (!has2) begin
					d_st = ST_UNF;
				end else begin
					d_wa[0] = cnt_m1[SP_W-1:0];
					d_wd[0] = t1_q;
					d_wa[1] = cnt_m2[SP_W-1:0];
					d_wd[1] = t0;
					d_wcnt  = 2'd2;
					d_top   = t1_q;
				end
			end
			OP_ROT: begin
				// third rises to the top, the upper two sink by one
				if (!has3) begin
					d_st = ST_UNF;
				end else begin
					d_wa[0] = cnt_m3[SP_W-1:0];
					d_wd[0] = t1_q;
					d_wa[1] = cnt_m2[SP_W-1:0];
					d_wd[1] = t0;
					d_wa[2] = cnt_m1[SP_W-1:0];
					d_wd[2] = t2_q;
					d_wcnt  = 2'd3;
					d_top   = t2_q;
				end
			end
			OP_IFEQ, OP_IFNE, OP_IFGT, OP_IFLT: begin
				d_nxt = pc2;
				if (!has1) begin
					d_st = ST_UNF;
				end else begin
					d_nn  = cnt_m1;
					d_top = pop_top;
					if (take)
						d_nxt = w_q[PC_BITS-1:0];
				end
			end
			OP_GOTO: d_nxt = w_q[PC_BITS-1:0];
			OP_EMIT: begin
				if (!has1) begin
					d_st = ST_UNF;
				end else begin
					d_nn   = cnt_m1;
					d_top  = pop_top;
					d_pv   = 1'b1;
					d_pval = t0;
				end
			end
			OP_HALT: d_st = ST_HALT;
			default: d_st = ST_UNK;
		endcase

		// Fault or stopped: leave everything as it was, except that a new fault sets the status
		if (stat_q != ST_RUN || (d_st != ST_RUN && d_st != ST_HALT)) begin
			if (stat_q != ST_RUN)
				d_st = stat_q;
			d_nn   = cnt_q;
			d_nxt  = pc_q;
			d_top  = top_q;
			d_pv   = 1'b0;
			d_pval = '0;
			d_vwr  = 1'b0;
			d_wcnt = 2'd0;
			d_div  = 1'b0;
		end
	end

	smeu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.is_mod   (op_q == OP_IMOD),
		.dividend (t1_q),
		.divisor  (t0),
		.done     (div_done),
		.result   (div_res)
	);

	// Register the plan; patch in the quotient or remainder when ready
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			st_q   <= d_st;
			nn_q   <= d_nn;
			nxt_q  <= d_nxt;
			ntop_q <= d_top;
			pv_q   <= d_pv;
			pval_q <= d_pval;
			vwr_q  <= d_vwr;
			wcnt_q <= d_wcnt;
			wa_q   <= d_wa;
			wd_q   <= d_wd;
		end else if (cmd.div_capture) begin
			wd_q[0] <= div_res;
			ntop_q  <= div_res;
		end
	end

	// Commit new state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			pc_q   <= '0;
			stat_q <= ST_RUN;
			top_q  <= '0;
		end else if (cmd.commit) begin
			cnt_q  <= nn_q;
			pc_q   <= nxt_q;
			stat_q <= st_q;
			top_q  <= ntop_q;
		end
	end

	// Output register: load on commit, drop on output transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ov_q <= 1'b0;
		else if (cmd.commit)
			ov_q <= 1'b1;
		else if (!out_stall)
			ov_q <= 1'b0;
	end

	assign pc_ext = WORD_W'(nxt_q);

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			o_pc_q    <= pc_ext[NPC_W-1:0];
			o_pv_q    <= pv_q;
			o_pval_q  <= pval_q;
			o_top_q   <= ntop_q;
			o_depth_q <= nn_q;
			o_st_q    <= st_q;
		end
	end

	assign out_valid   = ov_q;
	assign next_pc     = o_pc_q;
	assign print_valid = o_pv_q;
	assign print_value = o_pval_q;
	assign top_value   = o_top_q;
	assign depth       = o_depth_q;
	assign status      = o_st_q;

	assign sts.dec_div  = d_div;
	assign sts.div_done = div_done;
	assign sts.wr_count = wcnt_q;
	assign sts.out_free = !ov_q || !out_stall;

endmodule

FILE: rtl/stack_machine_execute_unit_core.sv
// Execute unit of a 32-bit stack machine. Each input transfer carries one
// fetched instruction (opcode and following program word); each produces
// exactly one result with the next fetch address, any printed value, the new
// stack top, the depth and the run status. The operand stack lives in a
// memory with one read and one write port, so an instruction reads the second
// and third entries and writes its stack updates one per cycle, and idiv/imod
// wait for the radix-2 divider. A new instruction is taken as soon as the
// previous one is committed, while its result may still wait in the output
// register. After a fault or halt every further instruction reports the held
// state.
`include "assert_macros.svh"

module stack_machine_execute_unit_core import smeu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         action,
	input  logic signed [31:0] operand,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        next_pc,
	output logic               print_valid,
	output logic signed [31:0] print_value,
	output logic signed [31:0] top_value,
	output logic [8:0]         depth,
	output logic [2:0]         status
);

	smeu_cmd_t   cmd;
	smeu_sts_t   sts;
	logic [92:0] result_bus;

	smeu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	smeu_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.action      (action),
		.operand     (operand),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.next_pc     (next_pc),
		.print_valid (print_valid),
		.print_value (print_value),
		.top_value   (top_value),
		.depth       (depth),
		.status      (status)
	);

	assign result_bus = {next_pc, print_valid, print_value, top_value, depth, status};

	`SMEU_ASSERT(a_print_running, out_valid && print_valid |-> status == ST_RUN, "print while stopped")
	`SMEU_ASSERT(a_depth_range, out_valid |-> depth <= CNT_W'(STACK_DEPTH), "depth out of range")
	`SMEU_ASSERT(a_commit_free, cmd.commit |-> !out_valid || !out_stall, "result overwritten")
	`SMEU_ASSERT_HOLD(a_out_hold, out_valid && out_stall, result_bus, "result changed while stalled")

endmodule

FILE: tb/stack_machine_execute_unit_checker.sv
module stack_machine_execute_unit_checker import smeu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  action,
	input  logic [31:0] operand,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [15:0] next_pc,
	input  logic        print_valid,
	input  logic [31:0] print_value,
	input  logic [31:0] top_value,
	input  logic [8:0]  depth,
	input  logic [2:0]  status,
	output int          errors,
	output int          pending
);

	typedef struct {
		logic [15:0] npc;
		logic        pv;
		logic [31:0] pval;
		logic [31:0] top;
		logic [8:0]  dep;
		logic [2:0]  st;
	} step_result_t;

	// shadow machine state
	logic [31:0] stack_mem [STACK_DEPTH];
	logic [31:0] var_mem [VAR_COUNT];
	int          stack_cnt;
	logic [15:0] pc_reg;
	logic [2:0]  run_st;

	step_result_t expected_steps [$];

	assign pending = expected_steps.size();

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
		errors++;
	endtask

	// execute one instruction on the shadow state and queue its result
	task automatic execute_step(input logic [7:0] op, input logic [31:0] w);
		logic [15:0] nxt;
		logic [2:0]  st;
		logic [31:0] a, b, c, pval;
		logic        pv, take;
		int          n;
		longint      q;
		step_result_t r;
		nxt = pc_reg + 16'd1;
		st = ST_RUN;
		pval = '0;
		pv = 1'b0;
		n = stack_cnt;
		if (run_st == ST_RUN) begin
			case (op)
				OP_NOP: ;
				OP_PUSH: begin
					nxt = pc_reg + 16'd2;
					if (n + 1 > STACK_DEPTH) st = ST_OVF;
					else begin stack_mem[n] = w; n++; end
				end
				OP_POP: if (n < 1) st = ST_UNF; else n--;
				OP_IADD, OP_ISUB, OP_IMUL, OP_IDIV, OP_IMOD,
				OP_AND, OP_OR, OP_XOR, OP_SHL, OP_SHR: begin
					if (n < 2) st = ST_UNF;
					else begin
						a = stack_mem[n-2];
						b = stack_mem[n-1];
						if ((op == OP_IDIV || op == OP_IMOD) && b == 0) st = ST_DIV0;
						else begin
							case (op)
								OP_IADD: c = a + b;
								OP_ISUB: c = a - b;
								OP_IMUL: c = a * b;
								OP_IDIV: begin
									q = longint'($signed(a)) / longint'($signed(b));
									c = q[31:0];
								end
								OP_IMOD: begin
									q = longint'($signed(a)) % longint'($signed(b));
									c = q[31:0];
								end
								OP_AND: c = a & b;
								OP_OR:  c = a | b;
								OP_XOR: c = a ^ b;
								OP_SHL: c = a << b[4:0];
								default: c = $signed(a) >>> b[4:0];
							endcase
							stack_mem[n-2] = c;
							n--;
						end
					end
				end
				OP_INC: if (n < 1) st = ST_UNF; else stack_mem[n-1] = stack_mem[n-1] + 1;
				OP_DEC: if (n < 1) st = ST_UNF; else stack_mem[n-1] = stack_mem[n-1] - 1;
				OP_NOT: if (n < 1) st = ST_UNF; else stack_mem[n-1] = ~stack_mem[n-1];
				OP_LDVAR: begin
					nxt = pc_reg + 16'd2;
					if (w[31] || w >= VAR_COUNT) st = ST_BADIDX;
					else if (n + 1 > STACK_DEPTH) st = ST_OVF;
					else begin stack_mem[n] = var_mem[w]; n++; end
				end
				OP_STVAR: begin
					nxt = pc_reg + 16'd2;
					if (n < 1) st = ST_UNF;
					else if (w[31] || w >= VAR_COUNT) st = ST_BADIDX;
					else begin n--; var_mem[w] = stack_mem[n]; end
				end
				OP_DUP: begin
					if (n < 1) st = ST_UNF;
					else if (n + 1 > STACK_DEPTH) st = ST_OVF;
					else begin stack_mem[n] = stack_mem[n-1]; n++; end
				end
				OP_SWAP: begin
					if (n < 2) st = ST_UNF;
					else begin
						a = stack_mem[n-1];
						stack_mem[n-1] = stack_mem[n-2];
						stack_mem[n-2] = a;
					end
				end
				OP_ROT: begin
					if (n < 3) st = ST_UNF;
					else begin
						a = stack_mem[n-1]; b = stack_mem[n-2]; c = stack_mem[n-3];
						stack_mem[n-3] = b; stack_mem[n-2] = a; stack_mem[n-1] = c;
					end
				end
				OP_IFEQ, OP_IFNE, OP_IFGT, OP_IFLT: begin
					nxt = pc_reg + 16'd2;
					if (n < 1) st = ST_UNF;
					else begin
						n--;
						a = stack_mem[n];
						case (op)
							OP_IFEQ: take = (a == 0);
							OP_IFNE: take = (a != 0);
							OP_IFGT: take = (a != 0 && !a[31]);
							default: take = a[31];
						endcase
						if (take) nxt = w[15:0];
					end
				end
				OP_GOTO: nxt = w[15:0];
				OP_EMIT: begin
					if (n < 1) st = ST_UNF;
					else begin n--; pval = stack_mem[n]; pv = 1'b1; end
				end
				OP_HALT: st = ST_HALT;
				default: st = ST_UNK;
			endcase
			// a fault keeps everything but the status
			if (st >= ST_OVF) begin
				run_st = st;
				pv = 1'b0;
				pval = '0;
			end else begin
				stack_cnt = n;
				pc_reg = nxt;
				run_st = st;
			end
		end
		r.npc = pc_reg;
		r.pv = pv;
		r.pval = pval;
		r.top = stack_cnt ? stack_mem[stack_cnt-1] : '0;
		r.dep = stack_cnt[8:0];
		r.st = run_st;
		expected_steps.push_back(r);
	endtask

	// compare result transfers first, then predict on input transfers
	always @(posedge clk or negedge arst_n) begin
		step_result_t e;
		if (!arst_n) begin
			for (int i = 0; i < STACK_DEPTH; i++) stack_mem[i] = '0;
			for (int i = 0; i < VAR_COUNT; i++) var_mem[i] = '0;
			stack_cnt = 0;
			pc_reg = '0;
			run_st = ST_RUN;
			errors = 0;
			expected_steps.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_steps.size() == 0) begin
					report("unexpected result transfer", 32'd1, 32'd0);
				end else begin
					e = expected_steps.pop_front();
					if (next_pc !== e.npc) report("next_pc", next_pc, e.npc);
					if (print_valid !== e.pv) report("print_valid", print_valid, e.pv);
					if (print_value !== e.pval) report("print_value", print_value, e.pval);
					if (top_value !== e.top) report("top_value", top_value, e.top);
					if (depth !== e.dep) report("depth", depth, e.dep);
					if (status !== e.st) report("status", status, e.st);
				end
			end
			if (in_valid && !in_stall) execute_step(action, operand);
		end
	end

endmodule

FILE: tb/testbench.sv
module testbench;
	import smeu_pkg::*;

	localparam int IDLE_LIMIT = 5000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [7:0]         action;
	logic signed [31:0] operand;
	logic               out_valid;
	logic               out_stall;
	logic [15:0]        next_pc;
	logic               print_valid;
	logic signed [31:0] print_value;
	logic signed [31:0] top_value;
	logic [8:0]         depth;
	logic [2:0]         status;
	int                 errors;
	int                 pending;
	int                 stack_level;
	int                 idle_cycles;
	int                 items_sent;
	bit                 send_calm;
	bit                 recv_calm;

	stack_machine_execute_unit_core i_dut (.*);

	stack_machine_execute_unit_checker i_checker (.*);

	// clock
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// draw a wait, with occasional stretches of back-to-back traffic
	function automatic int draw_wait(ref bit calm);
		if ($urandom_range(0, 39) == 0) calm = !calm;
		return calm ? 0 : $urandom_range(0, 7);
	endfunction

	// operands an opcode needs on the stack
	function automatic int operands_needed(input logic [7:0] op);
		case (op)
			OP_IADD, OP_ISUB, OP_IMUL, OP_IDIV, OP_IMOD, OP_AND, OP_OR, OP_XOR,
			OP_SHL, OP_SHR, OP_SWAP: return 2;
			OP_ROT: return 3;
			OP_POP, OP_INC, OP_DEC, OP_NOT, OP_STVAR, OP_DUP, OP_IFEQ, OP_IFNE,
			OP_IFGT, OP_IFLT, OP_EMIT: return 1;
			default: return 0;
		endcase
	endfunction

	// depth change of an instruction that does not fault
	function automatic int depth_change(input logic [7:0] op);
		case (op)
			OP_PUSH, OP_LDVAR, OP_DUP: return 1;
			OP_NOP, OP_INC, OP_DEC, OP_NOT, OP_SWAP, OP_ROT, OP_GOTO, OP_HALT: return 0;
			default: return (op > OP_HALT) ? 0 : -1;
		endcase
	endfunction

	// drive one instruction and hold it until the transfer
	task automatic issue(input logic [7:0] op, input logic [31:0] w);
		int gap;
		gap = draw_wait(send_calm);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		action <= op;
		operand <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		stack_level += depth_change(op);
		items_sent++;
	endtask

	function automatic logic [31:0] random_word();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 15);
			1: return -$urandom_range(1, 16);
			2: return {1'($urandom_range(0, 1)), 31'h0} | $urandom_range(0, 1);
			default: return $urandom;
		endcase
	endfunction

	// pick a legal instruction, padding the stack so nothing faults
	task automatic issue_random();
		logic [7:0]  op;
		logic [31:0] w;
		logic [31:0] divisor;
		op = 8'($urandom_range(OP_NOP, OP_EMIT));
		if (depth_change(op) > 0 && stack_level >= STACK_DEPTH - 4) op = OP_POP;
		while (stack_level < operands_needed(op)) issue(OP_PUSH, random_word());
		if (op == OP_IDIV || op == OP_IMOD) begin
			divisor = random_word();
			if (divisor == 0) divisor = 1;
			issue(OP_PUSH, divisor);
		end
		case (op)
			OP_PUSH: w = random_word();
			OP_LDVAR, OP_STVAR: w = $urandom_range(0, VAR_COUNT - 1);
			default: w = $urandom;
		endcase
		issue(op, w);
	endtask

	// result side: random stall before each transfer
	initial begin
		int n;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			n = draw_wait(recv_calm);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else if (idle_cycles == IDLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		int ending;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = OP_NOP;
		operand = '0;
		stack_level = 0;
		idle_cycles = 0;
		items_sent = 0;
		send_calm = 1'b0;
		recv_calm = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: wrap, divide overflow, shifts, stack shuffles, variables, branches, goto, emit
		issue(OP_PUSH, 32'h8000_0000);
		issue(OP_PUSH, 32'hFFFF_FFFF);
		issue(OP_IDIV, 32'h0);
		issue(OP_PUSH, 32'h8000_0000);
		issue(OP_PUSH, 32'hFFFF_FFFF);
		issue(OP_IMOD, 32'h0);
		issue(OP_PUSH, 32'h7FFF_FFFF);
		issue(OP_INC, 32'hFFFF_FFFF);
		issue(OP_PUSH, 32'd33);
		issue(OP_SHR, 32'h0);
		issue(OP_PUSH, 32'hFFFF_FFE1);
		issue(OP_SHL, 32'h0);
		issue(OP_ROT, 32'h0);
		issue(OP_SWAP, 32'h0);
		issue(OP_DUP, 32'h0);
		issue(OP_STVAR, VAR_COUNT - 1);
		issue(OP_LDVAR, VAR_COUNT - 1);
		issue(OP_LDVAR, 32'd0);
		issue(OP_NOT, 32'h0);
		issue(OP_IFLT, 32'hFFFF_1234);
		issue(OP_IFGT, 32'h0000_FFFF);
		issue(OP_DEC, 32'h0);
		issue(OP_IFEQ, 32'h0001_0000);
		issue(OP_IFNE, 32'h5555_AAAA);
		issue(OP_GOTO, 32'hFFFF_FFFF);
		issue(OP_EMIT, 32'h0);
		issue(OP_PUSH, 32'h1234_5678);
		issue(OP_NOP, 32'hAAAA_5555);
		issue(OP_POP, 32'h0);

		while (items_sent < 480) issue_random();

		// fill the stack to the top, then end with one stopping case
		while (stack_level < STACK_DEPTH) issue(OP_PUSH, $urandom);
		ending = $urandom_range(0, 5);
		if (ending == 0) begin
			case ($urandom_range(0, 2))
				0: issue(OP_PUSH, $urandom);
				1: issue(OP_DUP, $urandom);
				default: issue(OP_LDVAR, $urandom_range(0, VAR_COUNT - 1));
			endcase
		end else begin
			while (stack_level > 0) issue(OP_EMIT, $urandom);
			case (ending)
				1: begin
					case ($urandom_range(0, 3))
						0: issue(OP_POP, $urandom);
						1: issue(OP_ROT, $urandom);
						2: issue(OP_STVAR, 32'hFFFF_FFFF);
						default: issue(OP_IADD, $urandom);
					endcase
				end
				2: begin
					issue(OP_PUSH, $urandom);
					issue(OP_PUSH, 32'h0);
					issue($urandom_range(0, 1) ? OP_IDIV : OP_IMOD, $urandom);
				end
				3: begin
					issue(OP_PUSH, $urandom);
					issue($urandom_range(0, 1) ? OP_LDVAR : OP_STVAR,
						$urandom_range(0, 1) ? 32'h8000_0000 | $urandom : VAR_COUNT);
				end
				4: issue(8'($urandom_range(OP_HALT + 1, 255)), $urandom);
				default: issue(OP_HALT, $urandom);
			endcase
		end

		// stopped: any input just reports the held state
		repeat (20) issue(8'($urandom_range(0, 255)), $urandom);
		@(negedge clk);
		in_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/smeu_pkg.sv
rtl/smeu_div.sv
rtl/smeu_ctrl.sv
rtl/smeu_dp.sv
rtl/stack_machine_execute_unit_core.sv
tb/stack_machine_execute_unit_checker.sv
tb/testbench.sv
